FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define TLBS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define TLBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tlbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbs_pkg
// Types and constants of the thermal LED brightness slew block.
// ----------------------------------------------------------------------------
package tlbs_pkg;

    localparam int unsigned TempW  = 8;
    localparam int unsigned LevelW = 8;
    localparam int unsigned DelayW = 16;
    localparam int unsigned QuoW   = 16;

    typedef enum logic [2:0] {
        ACT_SAMPLE     = 3'd0,
        ACT_SUSPEND    = 3'd1,
        ACT_RESUME     = 3'd2,
        ACT_ACTIVATE   = 3'd3,
        ACT_DEACTIVATE = 3'd4
    } t_action;

    localparam logic [7:0] REG_BAND_LO   = 8'd0;
    localparam logic [7:0] REG_BAND_HI   = 8'd1;
    localparam logic [7:0] REG_DELAY_OFF = 8'd2;
    localparam logic [7:0] REG_DELAY_ON  = 8'd3;

    localparam logic [TempW-1:0]  RST_BAND_LO   = 8'd52;
    localparam logic [TempW-1:0]  RST_BAND_HI   = 8'd62;
    localparam logic [DelayW-1:0] RST_DELAY_OFF = 16'd500;
    localparam logic [DelayW-1:0] RST_DELAY_ON  = 16'd200;

    localparam logic [LevelW-1:0] FULL_LEVEL = 8'd255;

    // slew step bands
    localparam logic [QuoW-1:0] BAND_1  = 16'd10;
    localparam logic [QuoW-1:0] BAND_2  = 16'd20;
    localparam logic [QuoW-1:0] BAND_5  = 16'd40;
    localparam logic [QuoW-1:0] BAND_10 = 16'd120;

endpackage

FILE: design/tlbs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tlbs_div
    import tlbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [QuoW-1:0]   i_dividend,
    input  logic [TempW-1:0]  i_divisor,
    output logic              o_done,
    output logic [QuoW-1:0]   o_quotient
);

    localparam int unsigned CntW = $clog2(QuoW);

    logic              r_busy;
    logic [CntW-1:0]   r_cnt;
    logic [TempW-1:0]  r_rem;
    logic [TempW-1:0]  r_dvs;
    logic [QuoW-1:0]   r_quo;
    logic              r_done;

    logic [TempW:0]    shifted;
    logic              fits;
    logic [TempW:0]    diff;

    assign shifted = {r_rem, r_quo[QuoW-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign fits    = (shifted >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                // shift in the next dividend bit, subtract when it fits
                r_rem <= fits ? diff[TempW-1:0] : shifted[TempW-1:0];
                r_quo <= {r_quo[QuoW-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(QuoW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: design/thermal_led_brightness_slew.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_led_brightness_slew
// Temperature driven LED brightness controller with distance based slew.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) takes one action word: sample, suspend,
//   resume, activate or deactivate, with temperature and read status.
//   Output channel (o_valid/i_ready) returns exactly one result word per
//   action: LED write flag and level, rearm flag and next poll delay.
//   Config channel (i_cfg_valid/o_cfg_ready) writes the band limits and the
//   two poll delays by index; always ready.
//   One item at a time: o_ready drops after an accept. A good sample inside
//   the band runs the bit-serial divider in S_DIV, then S_SLEW and S_DONE;
//   other good samples pass S_SLEW and S_DONE, other actions only S_DONE.
//   o_ready returns with o_valid.
//   A stalled receiver holds o_valid and the word; the next item is taken
//   meanwhile but its result waits.
//   Reset clears level, last written level, active and suspended, and
//   loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module thermal_led_brightness_slew
    import tlbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_action,
    input  logic [TempW-1:0]  i_temperature,
    input  logic              i_read_ok,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_led_write,
    output logic [LevelW-1:0] o_led_level,
    output logic              o_rearm,
    output logic [DelayW-1:0] o_next_delay_ticks,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SLEW,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [TempW-1:0]   r_low;
    logic [TempW-1:0]   r_high;
    logic [DelayW-1:0]  r_dly_off;
    logic [DelayW-1:0]  r_dly_on;
    logic [LevelW-1:0]  r_level;
    logic [LevelW-1:0]  r_last;
    logic               r_active;
    logic               r_susp;
    logic [QuoW-1:0]    r_target;
    logic               r_p_wr;
    logic [LevelW-1:0]  r_p_lv;
    logic               r_p_rearm;
    logic [DelayW-1:0]  r_p_dly;
    logic               r_o_valid;
    logic               r_o_wr;
    logic [LevelW-1:0]  r_o_lv;
    logic               r_o_rearm;
    logic [DelayW-1:0]  r_o_dly;

    logic               in_acc;
    logic               run_sample;
    logic               in_band;
    logic               div_start;
    logic               div_done;
    logic [QuoW-1:0]    div_quo;
    logic [TempW-1:0]   temp_ofs;
    logic [QuoW-1:0]    dividend;
    logic [DelayW-1:0]  cur_dly;
    logic               out_load;

    // action decode
    t_state             n_state;
    logic               n_p_wr;
    logic               n_p_rearm;
    logic [DelayW-1:0]  n_p_dly;

    // slew datapath
    logic [QuoW-1:0]    lvl_w;
    logic               up;
    logic [QuoW-1:0]    delta;
    logic               big;
    logic [3:0]         stepv;
    logic [LevelW:0]    sum;
    logic [LevelW:0]    dif;
    logic [LevelW-1:0]  n_level;

    assign in_acc     = i_valid && o_ready;
    assign run_sample = r_active && !r_susp;
    assign in_band    = (i_temperature > r_low) && (r_high > r_low);
    assign temp_ofs   = i_temperature - r_low;
    // 255 * x as (x << 8) - x
    assign dividend   = {temp_ofs, 8'd0} - {8'd0, temp_ofs};
    assign cur_dly    = (r_level == '0) ? r_dly_off : r_dly_on;
    assign out_load   = (r_state == S_DONE) && (!r_o_valid || i_ready);

    assign div_start = in_acc && (i_action == ACT_SAMPLE) && run_sample
                       && i_read_ok && in_band;

    tlbs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_high - r_low),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state   = S_DONE;
        n_p_wr    = 1'b0;
        n_p_rearm = 1'b0;
        n_p_dly   = '0;
        case (i_action)
            ACT_SAMPLE: begin
                if (run_sample) begin
                    if (!i_read_ok) begin
                        n_p_rearm = 1'b1;
                        n_p_dly   = cur_dly;
                    end else if (in_band) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_SLEW;
                    end
                end
            end
            ACT_SUSPEND: begin
                n_p_wr = r_active && (r_level != '0);
            end
            ACT_RESUME: begin
                n_p_rearm = r_active;
                n_p_dly   = r_active ? cur_dly : '0;
            end
            ACT_ACTIVATE: begin
                n_p_rearm = 1'b1;
                n_p_dly   = r_dly_off;
            end
            ACT_DEACTIVATE: begin
                n_p_wr = r_active;
            end
            default: ;
        endcase
    end

    always_comb begin
        lvl_w = {8'd0, r_level};
        up    = r_target > lvl_w;
        delta = up ? (r_target - lvl_w) : (lvl_w - r_target);
        big   = (delta >= BAND_10);
        if (delta < BAND_1) begin
            stepv = 4'd1;
        end else if (delta < BAND_2) begin
            stepv = 4'd2;
        end else if (delta < BAND_5) begin
            stepv = 4'd5;
        end else begin
            stepv = 4'd10;
        end
        sum = {1'b0, r_level} + {5'd0, stepv};
        dif = {1'b0, r_level} - {5'd0, stepv};
        if (up) begin
            if (big) begin
                n_level = (r_target > {8'd0, FULL_LEVEL}) ? FULL_LEVEL
                                                          : r_target[LevelW-1:0];
            end else begin
                n_level = sum[LevelW] ? FULL_LEVEL : sum[LevelW-1:0];
            end
        end else begin
            if (big) begin
                n_level = r_target[LevelW-1:0];
            end else begin
                // borrow means it went below zero
                n_level = dif[LevelW] ? '0 : dif[LevelW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_low     <= RST_BAND_LO;
            r_high    <= RST_BAND_HI;
            r_dly_off <= RST_DELAY_OFF;
            r_dly_on  <= RST_DELAY_ON;
            r_level   <= '0;
            r_last    <= '0;
            r_active  <= 1'b0;
            r_susp    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_BAND_LO:   r_low     <= i_cfg_data[TempW-1:0];
                    REG_BAND_HI:   r_high    <= i_cfg_data[TempW-1:0];
                    REG_DELAY_OFF: r_dly_off <= i_cfg_data;
                    REG_DELAY_ON:  r_dly_on  <= i_cfg_data;
                    default: ;
                endcase
            end

            // move the word out once the output register is free
            if (out_load) begin
                r_o_valid <= 1'b1;
                r_o_wr    <= r_p_wr;
                r_o_lv    <= r_p_lv;
                r_o_rearm <= r_p_rearm;
                r_o_dly   <= r_p_dly;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_p_wr    <= n_p_wr;
                        r_p_lv    <= '0;
                        r_p_rearm <= n_p_rearm;
                        r_p_dly   <= n_p_dly;
                        r_state   <= n_state;
                        // out of band target; an in-band sample takes the quotient
                        r_target  <= (i_temperature <= r_low) ? '0
                                     : {8'd0, FULL_LEVEL};
                        case (i_action)
                            ACT_SUSPEND: begin
                                if (r_active) begin
                                    r_susp <= 1'b1;
                                end
                            end
                            ACT_RESUME: begin
                                if (r_active) begin
                                    r_susp <= 1'b0;
                                end
                            end
                            ACT_ACTIVATE: begin
                                r_level  <= '0;
                                r_last   <= '0;
                                r_susp   <= 1'b0;
                                r_active <= 1'b1;
                            end
                            ACT_DEACTIVATE: begin
                                if (r_active) begin
                                    r_level  <= '0;
                                    r_last   <= '0;
                                    r_susp   <= 1'b0;
                                    r_active <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_target <= div_quo;
                        r_state  <= S_SLEW;
                    end
                end
                S_SLEW: begin
                    r_level   <= n_level;
                    r_p_rearm <= 1'b1;
                    r_p_dly   <= (n_level == '0) ? r_dly_off : r_dly_on;
                    if (n_level != r_last) begin
                        r_last <= n_level;
                        r_p_wr <= 1'b1;
                        r_p_lv <= n_level;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready            = (r_state == S_IDLE);
    assign o_cfg_ready        = 1'b1;
    assign o_valid            = r_o_valid;
    assign o_led_write        = r_o_wr;
    assign o_led_level        = r_o_lv;
    assign o_rearm            = r_o_rearm;
    assign o_next_delay_ticks = r_o_dly;

endmodule

FILE: design/tlbs_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbs_chk
// Port level checks of the thermal LED brightness slew block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlbs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [2:0]  i_action,
    input logic [7:0]  i_temperature,
    input logic        i_read_ok,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_led_write,
    input logic [7:0]  o_led_level,
    input logic        o_rearm,
    input logic [15:0] o_next_delay_ticks,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [7:0]  i_cfg_index,
    input logic [15:0] i_cfg_data
);

    // a pending word holds until taken
    `TLBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_led_write) && $stable(o_led_level) && $stable(o_rearm) && $stable(o_next_delay_ticks), "output word changed while stalled")

    // no level is shown without a write
    `TLBS_ASSERT(a_lv_zero, i_clk, i_rst_n, !(o_valid && !o_led_write) || (o_led_level == 8'd0), "led level nonzero without write")

    // no delay is shown without a rearm
    `TLBS_ASSERT(a_dly_zero, i_clk, i_rst_n, !(o_valid && !o_rearm) || (o_next_delay_ticks == 16'd0), "delay nonzero without rearm")

    // one item at a time
    `TLBS_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "input taken while busy")

endmodule

bind thermal_led_brightness_slew tlbs_chk u_tlbs_chk (.*);
